@@ sv/dexp_pkg.sv @@
// shared types, widths, microcode program and codes for the smoothing forecaster
// no dependencies; imported by dexp_seq, dexp_dp and the top level
package dexp_pkg;

    // field and datapath widths
    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int LEVEL_W  = 32;
    localparam int ALPHA_W  = 16;
    localparam int GAIN_W   = 32;
    localparam int CNT_W    = 16;
    localparam int FC_W     = 40;
    localparam int SSUM_W   = 40;
    localparam int LSUM_W   = 48;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 56;
    localparam int DATA_W   = CNT_W + 2 * LEVEL_W + FC_W + SSUM_W + 3 * LSUM_W;
    localparam int PC_W     = 5;

    // register reset values
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd19661;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 32'd28087;

    // configuration register indexes
    localparam logic [0:0] CFG_ALPHA = 1'b0;
    localparam logic [0:0] CFG_GAIN  = 1'b1;

    // datapath operations, one per control word
    typedef enum logic [4:0] {
        OP_NOP,
        OP_WAIT,
        OP_EMIT,
        OP_DIFF1,
        OP_UPD1,
        OP_DIFF2,
        OP_UPD2,
        OP_TREND,
        OP_SLOPE,
        OP_FC_TREND,
        OP_MISS,
        OP_EXT_HI,
        OP_EXT_LO,
        OP_ACC_HI,
        OP_ACC_LO,
        OP_FC_EXT,
        OP_SUMS,
        OP_SEED
    } t_op;

    // jump conditions; a true condition loads the target, else the step advances
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_NOT_STARTED,
        C_ZERO,
        C_OUT_BUSY
    } t_cond;

    typedef logic [PC_W-1:0] t_pc;

    // program step addresses
    localparam t_pc A_EMIT    = 5'd0;
    localparam t_pc A_WAIT    = 5'd1;
    localparam t_pc A_CHK     = 5'd2;
    localparam t_pc A_MUL1    = 5'd3;
    localparam t_pc A_UPD1    = 5'd4;
    localparam t_pc A_DIFF2   = 5'd5;
    localparam t_pc A_MUL2    = 5'd6;
    localparam t_pc A_UPD2    = 5'd7;
    localparam t_pc A_TREND   = 5'd8;
    localparam t_pc A_MUL3    = 5'd9;
    localparam t_pc A_SLOPE   = 5'd10;
    localparam t_pc A_FCT     = 5'd11;
    localparam t_pc A_MISS    = 5'd12;
    localparam t_pc A_EXT_HI  = 5'd13;
    localparam t_pc A_EXT_LO  = 5'd14;
    localparam t_pc A_ACC_HI  = 5'd15;
    localparam t_pc A_ACC_LO  = 5'd16;
    localparam t_pc A_FCX     = 5'd17;
    localparam t_pc A_SUMS    = 5'd18;
    localparam t_pc A_SEED    = 5'd19;
    localparam t_pc A_LAST    = A_SEED;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // control from sequencer to datapath and handshake logic
    typedef struct packed {
        t_pc pc;
        t_op op;
    } t_ctrl;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic started;
        logic sample_zero;
    } t_dp_stat;

    typedef struct packed {
        t_dp_stat dp;
        logic     in_valid;
        logic     out_busy;
    } t_seq_stat;

    // one result word
    typedef struct packed {
        logic        [LSUM_W-1:0]  sum_forecast;
        logic        [LSUM_W-1:0]  sum_level_second;
        logic        [LSUM_W-1:0]  sum_level_first;
        logic        [SSUM_W-1:0]  sum_samples;
        logic        [FC_W-1:0]    forecast_value;
        logic        [LEVEL_W-1:0] level_second;
        logic        [LEVEL_W-1:0] level_first;
        logic        [CNT_W-1:0]   sample_index;
        logic                      extrapolating;
    } t_result;

    // microcode rom: every multiply takes an operand step, a product step and a use step
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            A_EMIT:   w = '{OP_EMIT,     C_OUT_BUSY,    A_EMIT};
            A_WAIT:   w = '{OP_WAIT,     C_NO_INPUT,    A_WAIT};
            A_CHK:    w = '{OP_DIFF1,    C_NOT_STARTED, A_SEED};
            A_MUL1:   w = '{OP_NOP,      C_NEXT,        A_WAIT};
            A_UPD1:   w = '{OP_UPD1,     C_NEXT,        A_WAIT};
            A_DIFF2:  w = '{OP_DIFF2,    C_NEXT,        A_WAIT};
            A_MUL2:   w = '{OP_NOP,      C_NEXT,        A_WAIT};
            A_UPD2:   w = '{OP_UPD2,     C_ZERO,        A_MISS};
            A_TREND:  w = '{OP_TREND,    C_NEXT,        A_WAIT};
            A_MUL3:   w = '{OP_NOP,      C_NEXT,        A_WAIT};
            A_SLOPE:  w = '{OP_SLOPE,    C_NEXT,        A_WAIT};
            A_FCT:    w = '{OP_FC_TREND, C_ALWAYS,      A_SUMS};
            A_MISS:   w = '{OP_MISS,     C_NEXT,        A_WAIT};
            A_EXT_HI: w = '{OP_EXT_HI,   C_NEXT,        A_WAIT};
            A_EXT_LO: w = '{OP_EXT_LO,   C_NEXT,        A_WAIT};
            A_ACC_HI: w = '{OP_ACC_HI,   C_NEXT,        A_WAIT};
            A_ACC_LO: w = '{OP_ACC_LO,   C_NEXT,        A_WAIT};
            A_FCX:    w = '{OP_FC_EXT,   C_NEXT,        A_WAIT};
            A_SUMS:   w = '{OP_SUMS,     C_ALWAYS,      A_EMIT};
            A_SEED:   w = '{OP_SEED,     C_ALWAYS,      A_EMIT};
            default:  w = '{OP_NOP,      C_ALWAYS,      A_WAIT};
        endcase
        return w;
    endfunction

endpackage

@@ sv/dexp_seq.sv @@
// microcode sequencer: step counter, program rom lookup and conditional jumps
// depends on dexp_pkg
module dexp_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dexp_pkg::t_seq_stat  i_stat,
    output dexp_pkg::t_ctrl      o_ctrl
);
    import dexp_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_word;
    logic   w_take;

    // fetch current control word
    assign w_word = ucode(r_pc);

    // jump condition
    always_comb begin
        case (w_word.cond)
            C_NEXT:        w_take = 1'b0;
            C_ALWAYS:      w_take = 1'b1;
            C_NO_INPUT:    w_take = !i_stat.in_valid;
            C_NOT_STARTED: w_take = !i_stat.dp.started;
            C_ZERO:        w_take = i_stat.dp.sample_zero;
            C_OUT_BUSY:    w_take = i_stat.out_busy;
            default:       w_take = 1'b0;
        endcase
        n_pc = w_take ? w_word.target : t_pc'(r_pc + 1'b1);
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.pc = r_pc;
    assign o_ctrl.op = w_word.op;

endmodule

@@ sv/dexp_dp.sv @@
// datapath: smoothed levels, trend, forecast and running sums around one shared multiplier
// depends on dexp_pkg; driven by the control words of dexp_seq
module dexp_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dexp_pkg::t_ctrl                i_ctrl,
    input  logic                           i_accept,
    input  logic [dexp_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [dexp_pkg::ALPHA_W-1:0]   i_alpha,
    input  logic [dexp_pkg::GAIN_W-1:0]    i_gain,
    output dexp_pkg::t_dp_stat             o_stat,
    output dexp_pkg::t_result              o_result
);
    import dexp_pkg::*;

    localparam int SR_W  = PROD_W - FRAC_W + 1;
    localparam int EXT_W = ACC_W + 2;
    localparam int HI_W  = FC_W - FRAC_W;
    localparam logic [SR_W-1:0] SLOPE_POS_MAX = SR_W'((65'd1 << (FC_W - 1)) - 65'd1);
    localparam logic [SR_W-1:0] SLOPE_NEG_MAX = SR_W'(65'd1 << (FC_W - 1));
    localparam logic [FC_W-1:0] FC_MAX = {1'b0, {(FC_W-1){1'b1}}};
    localparam logic [FC_W-1:0] FC_MIN = {1'b1, {(FC_W-1){1'b0}}};
    localparam logic [LSUM_W-1:0] LSUM_MAX = {1'b0, {(LSUM_W-1){1'b1}}};
    localparam logic [LSUM_W-1:0] LSUM_MIN = {1'b1, {(LSUM_W-1){1'b0}}};

    // architectural state
    logic                      r_started;
    logic [SAMPLE_W-1:0]       r_prev;
    logic [LEVEL_W-1:0]        r_l1;
    logic [LEVEL_W-1:0]        r_l2;
    logic signed [FC_W-1:0]    r_icpt;
    logic signed [FC_W-1:0]    r_slope;
    logic [CNT_W-1:0]          r_miss;
    logic [CNT_W-1:0]          r_cnt;
    logic [SSUM_W-1:0]         r_ssum;
    logic [LSUM_W-1:0]         r_sum1;
    logic [LSUM_W-1:0]         r_sum2;
    logic signed [LSUM_W-1:0]  r_sumfc;

    // working registers
    logic [SAMPLE_W-1:0]       r_s;
    logic [MUL_W-1:0]          r_opa;
    logic [MUL_W-1:0]          r_opb;
    logic                      r_dir;
    logic [PROD_W-1:0]         r_prod;
    logic [ACC_W-1:0]          r_acc;
    logic signed [FC_W-1:0]    r_fc;
    logic                      r_extra;

    // combinational helpers
    logic [LEVEL_W-1:0]        w_tgt1;
    logic                      w_ge1;
    logic [LEVEL_W-1:0]        w_d1;
    logic                      w_ge2;
    logic [LEVEL_W-1:0]        w_d2;
    logic [LEVEL_W:0]          w_rnd;
    logic [LEVEL_W-1:0]        w_step;
    logic [SR_W-1:0]           w_srnd;
    logic [FC_W-1:0]           w_smag;
    logic [FC_W-1:0]           w_slope_mag;
    logic [FC_W:0]             w_ft;
    logic [FC_W-1:0]           w_ft_sat;
    logic [EXT_W-1:0]          w_ext;
    logic [FC_W-1:0]           w_ext_sat;
    logic [FC_W-1:0]           w_icpt;
    logic [LEVEL_W-1:0]        w_seed_lvl;
    logic [SSUM_W:0]           w_ss;
    logic [LSUM_W:0]           w_s1;
    logic [LSUM_W:0]           w_s2;
    logic [LSUM_W:0]           w_sf;

    // level differences and rounded level step
    always_comb begin
        w_tgt1     = {r_prev, {FRAC_W{1'b0}}};
        w_seed_lvl = {r_s, {FRAC_W{1'b0}}};
        w_ge1      = (w_tgt1 >= r_l1);
        w_d1       = w_ge1 ? (w_tgt1 - r_l1) : (r_l1 - w_tgt1);
        w_ge2      = (r_l1 >= r_l2);
        w_d2       = w_ge2 ? (r_l1 - r_l2) : (r_l2 - r_l1);
        w_rnd      = {1'b0, r_prod[FRAC_W +: LEVEL_W]} + {{LEVEL_W{1'b0}}, r_prod[FRAC_W-1]};
        w_step     = w_rnd[LEVEL_W-1:0];
    end

    // slope rounding and caps, intercept 2*l1 - l2 (never leaves 40 bits)
    always_comb begin
        w_srnd = {1'b0, r_prod[PROD_W-1:FRAC_W]} + {{(SR_W-1){1'b0}}, r_prod[FRAC_W-1]};
        if (r_dir) begin
            w_smag = (w_srnd > SLOPE_POS_MAX) ? SLOPE_POS_MAX[FC_W-1:0] : w_srnd[FC_W-1:0];
        end else begin
            w_smag = (w_srnd > SLOPE_NEG_MAX) ? SLOPE_NEG_MAX[FC_W-1:0] : w_srnd[FC_W-1:0];
        end
        w_slope_mag = r_slope[FC_W-1] ? (FC_W'(0) - r_slope) : r_slope;
        w_icpt = {{(FC_W-LEVEL_W-1){1'b0}}, r_l1, 1'b0} - {{(FC_W-LEVEL_W){1'b0}}, r_l2};
    end

    // forecasts with saturation to 40 bits
    always_comb begin
        w_ft = {r_icpt[FC_W-1], r_icpt} + {r_slope[FC_W-1], r_slope};
        if (w_ft[FC_W] != w_ft[FC_W-1]) begin
            w_ft_sat = w_ft[FC_W] ? FC_MIN : FC_MAX;
        end else begin
            w_ft_sat = w_ft[FC_W-1:0];
        end
        if (r_slope[FC_W-1]) begin
            w_ext = {{(EXT_W-FC_W){r_icpt[FC_W-1]}}, r_icpt} - {2'b00, r_acc};
        end else begin
            w_ext = {{(EXT_W-FC_W){r_icpt[FC_W-1]}}, r_icpt} + {2'b00, r_acc};
        end
        if ((&w_ext[EXT_W-1:FC_W-1]) || !(|w_ext[EXT_W-1:FC_W-1])) begin
            w_ext_sat = w_ext[FC_W-1:0];
        end else begin
            w_ext_sat = w_ext[EXT_W-1] ? FC_MIN : FC_MAX;
        end
    end

    // running sums before saturation
    always_comb begin
        w_ss = {1'b0, r_ssum} + {{(SSUM_W-SAMPLE_W+1){1'b0}}, r_s};
        w_s1 = {1'b0, r_sum1} + {{(LSUM_W-LEVEL_W+1){1'b0}}, r_l1};
        w_s2 = {1'b0, r_sum2} + {{(LSUM_W-LEVEL_W+1){1'b0}}, r_l2};
        w_sf = {r_sumfc[LSUM_W-1], r_sumfc} + {{(LSUM_W-FC_W+1){r_fc[FC_W-1]}}, r_fc};
    end

    // shared multiplier, product registered every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= r_opa * r_opb;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s <= i_sample;
        end
        case (i_ctrl.op)
            OP_DIFF1: begin
                r_dir   <= w_ge1;
                r_opa   <= w_d1;
                r_opb   <= {{(MUL_W-ALPHA_W){1'b0}}, i_alpha};
                r_extra <= 1'b0;
            end
            OP_DIFF2: begin
                r_dir <= w_ge2;
                r_opa <= w_d2;
                r_opb <= {{(MUL_W-ALPHA_W){1'b0}}, i_alpha};
            end
            OP_TREND: begin
                r_dir <= w_ge2;
                r_opa <= w_d2;
                r_opb <= i_gain;
            end
            OP_FC_TREND: r_fc <= w_ft_sat;
            OP_MISS:     r_extra <= 1'b1;
            OP_EXT_HI: begin
                r_opa <= {{(MUL_W-HI_W){1'b0}}, w_slope_mag[FC_W-1:FRAC_W]};
                r_opb <= {{(MUL_W-CNT_W){1'b0}}, r_miss};
            end
            OP_EXT_LO:   r_opa <= {{(MUL_W-FRAC_W){1'b0}}, w_slope_mag[FRAC_W-1:0]};
            OP_ACC_HI:   r_acc <= {r_prod[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            OP_ACC_LO:   r_acc <= r_acc + r_prod[ACC_W-1:0];
            OP_FC_EXT:   r_fc <= w_ext_sat;
            OP_SEED: begin
                r_fc    <= {{(FC_W-LEVEL_W){1'b0}}, w_seed_lvl};
                r_extra <= 1'b0;
            end
            default: ;
        endcase
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_prev    <= '0;
            r_l1      <= '0;
            r_l2      <= '0;
            r_icpt    <= '0;
            r_slope   <= '0;
            r_miss    <= '0;
            r_cnt     <= '0;
            r_ssum    <= '0;
            r_sum1    <= '0;
            r_sum2    <= '0;
            r_sumfc   <= '0;
        end else begin
            case (i_ctrl.op)
                OP_UPD1: r_l1 <= r_dir ? (r_l1 + w_step) : (r_l1 - w_step);
                OP_UPD2: begin
                    r_l2 <= r_dir ? (r_l2 + w_step) : (r_l2 - w_step);
                    if (r_cnt != {CNT_W{1'b1}}) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                OP_TREND: r_icpt <= w_icpt;
                OP_SLOPE: r_slope <= r_dir ? w_smag : (FC_W'(0) - w_smag);
                OP_MISS: begin
                    if (r_miss != {CNT_W{1'b1}}) begin
                        r_miss <= r_miss + 1'b1;
                    end
                end
                OP_SUMS: begin
                    r_ssum <= w_ss[SSUM_W] ? {SSUM_W{1'b1}} : w_ss[SSUM_W-1:0];
                    r_sum1 <= w_s1[LSUM_W] ? {LSUM_W{1'b1}} : w_s1[LSUM_W-1:0];
                    r_sum2 <= w_s2[LSUM_W] ? {LSUM_W{1'b1}} : w_s2[LSUM_W-1:0];
                    if (w_sf[LSUM_W] != w_sf[LSUM_W-1]) begin
                        r_sumfc <= w_sf[LSUM_W] ? LSUM_MIN : LSUM_MAX;
                    end else begin
                        r_sumfc <= w_sf[LSUM_W-1:0];
                    end
                end
                OP_EMIT: r_prev <= r_s;
                OP_SEED: begin
                    r_started <= 1'b1;
                    r_l1      <= w_seed_lvl;
                    r_l2      <= w_seed_lvl;
                    r_cnt     <= '0;
                    r_ssum    <= {{(SSUM_W-SAMPLE_W){1'b0}}, r_s};
                    r_sum1    <= {{(LSUM_W-LEVEL_W){1'b0}}, w_seed_lvl};
                    r_sum2    <= {{(LSUM_W-LEVEL_W){1'b0}}, w_seed_lvl};
                    r_sumfc   <= {{(LSUM_W-LEVEL_W){1'b0}}, w_seed_lvl};
                end
                default: ;
            endcase
        end
    end

    // status and result
    assign o_stat.started     = r_started;
    assign o_stat.sample_zero = (r_s == '0);

    assign o_result.sum_forecast     = r_sumfc;
    assign o_result.sum_level_second = r_sum2;
    assign o_result.sum_level_first  = r_sum1;
    assign o_result.sum_samples      = r_ssum;
    assign o_result.forecast_value   = r_fc;
    assign o_result.level_second     = r_l2;
    assign o_result.level_first      = r_l1;
    assign o_result.sample_index     = r_cnt;
    assign o_result.extrapolating    = r_extra;

endmodule

@@ sv/double_exponential_smoothing_forecaster.sv @@
// Brown double exponential smoothing forecaster, one 16-bit sample per input word and one
// result word per sample. The first sample seeds both levels and the sums; a later sample
// with a value runs the level updates, trend and forecast, and a missing (zero) sample
// the level updates and extrapolation; the result register is loaded once the previous
// result has left it. The microcode program runs every multiply through one shared 32x32
// multiplier as an operand step, a product step and a use step; the extrapolation product
// is formed from two partial products. A new sample is taken only in the program's wait
// step, while a finished result may still be held for the sink. The user writes
// configuration (alpha and trend gain) only while idle; the block does not enforce this.
// depends on dexp_pkg, dexp_seq and dexp_dp
module double_exponential_smoothing_forecaster (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample[15:0]
    input  logic [dexp_pkg::SAMPLE_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // sample_index, level_first, level_second, forecast_value, sum_samples,
    // sum_level_first, sum_level_second, sum_forecast
    output logic [dexp_pkg::DATA_W-1:0]    m_axis_tdata,
    // extrapolating
    output logic                           m_axis_tuser,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_idx,
    input  logic [dexp_pkg::GAIN_W-1:0]    i_cfg_data
);
    import dexp_pkg::*;

    logic [ALPHA_W-1:0] r_alpha;
    logic [GAIN_W-1:0]  r_gain;
    logic               r_mvalid;
    logic [DATA_W-1:0]  r_mdata;
    logic               r_muser;

    t_ctrl              w_ctrl;
    t_dp_stat           w_dp_stat;
    t_seq_stat          w_seq_stat;
    t_result            w_result;
    logic               w_accept;
    logic               w_out_free;
    logic               w_out_load;

    // handshake
    assign s_axis_tready = (w_ctrl.op == OP_WAIT);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_mvalid || m_axis_tready;
    assign w_out_load    = (w_ctrl.op == OP_EMIT) && w_out_free;

    assign w_seq_stat.dp       = w_dp_stat;
    assign w_seq_stat.in_valid = s_axis_tvalid;
    assign w_seq_stat.out_busy = !w_out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_gain  <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHA: r_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_GAIN:  r_gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dexp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_seq_stat),
        .o_ctrl  (w_ctrl)
    );

    dexp_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_accept (w_accept),
        .i_sample (s_axis_tdata),
        .i_alpha  (r_alpha),
        .i_gain   (r_gain),
        .o_stat   (w_dp_stat),
        .o_result (w_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_out_load) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_mdata <= {w_result.sum_forecast, w_result.sum_level_second,
                        w_result.sum_level_first, w_result.sum_samples,
                        w_result.forecast_value, w_result.level_second,
                        w_result.level_first, w_result.sample_index};
            r_muser <= w_result.extrapolating;
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;

`ifndef SYNTH
    // after taking a sample the program leaves the wait step at once
    a_accept_leaves_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("input still ready right after a sample was taken");

    // a result is only produced once the levels have been seeded
    a_emit_after_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> w_dp_stat.started)
        else $error("result emitted before the first sample seeded the state");

    // step counter stays inside the program
    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.pc <= A_LAST)
        else $error("sequencer step counter left the program");
`endif

endmodule
